### rtl/double_ended_queue_with_search_defines.svh
// Assertion macros for the port-level checker of the deque block.
// Depends on nothing; the using module must provide clk and rst.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

// Property checked outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/deq_pkg.sv
// Shared types, field widths and request/status codes of the deque block.
// Used by the channel interfaces, the top level and the checker.
package deq_pkg;

  // Default number of entries.
  localparam int DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [REQ_W-1:0]         req_t;
  typedef logic [STAT_W-1:0]        status_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [CNT_OUT_W-1:0]     cnt_t;

  // Request codes.
  localparam req_t REQ_PUSH_FRONT   = 3'd0;
  localparam req_t REQ_PUSH_BACK    = 3'd1;
  localparam req_t REQ_REMOVE_FRONT = 3'd2;
  localparam req_t REQ_REMOVE_BACK  = 3'd3;
  localparam req_t REQ_SEARCH       = 3'd4;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

### rtl/deq_req_if.sv
// Request channel of the deque block: valid/ready handshake with payload.
// Depends on deq_pkg.
interface deq_req_if;
  logic          valid;
  logic          ready;
  deq_pkg::req_t  req_type;
  deq_pkg::data_t value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

### rtl/deq_rsp_if.sv
// Result channel of the deque block: valid/ready handshake with payload.
// Depends on deq_pkg.
interface deq_rsp_if;
  logic             valid;
  logic             ready;
  deq_pkg::status_t status;
  logic             found;
  deq_pkg::pos_t    found_pos;
  deq_pkg::data_t   front_item;
  deq_pkg::data_t   back_item;
  deq_pkg::cnt_t    entry_count;
  logic             is_empty;

  modport source (output valid, output status, output found, output found_pos,
                  output front_item, output back_item, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input found, input found_pos,
                  input front_item, input back_item, input entry_count,
                  input is_empty, output ready);
endinterface

### rtl/deq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/double_ended_queue_with_search.sv
// Bounded double-ended queue with linear search, held as a circular buffer
// in one RAM with a single read and a single write port. One request is in
// work at a time, and a finished result sits in the output register so the
// next request is taken while it waits. A push passes the execute and done
// states; a removal adds a load state for the new end entry from the RAM,
// skipped when it empties the queue or hits an empty queue; a search scans
// from the front until the match or the last entry, and the RAM read port
// delivers one entry per cycle to the compare. Front and back values are
// cached in registers; removals refresh them with one RAM read.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and deq_ram.
module double_ended_queue_with_search #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [PTR_W-1:0] front_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] kc;
  deq_pkg::data_t   front_q;
  deq_pkg::data_t   back_q;
  deq_pkg::req_t    req_type_q;
  deq_pkg::data_t   value_q;
  deq_pkg::status_t status_q;
  logic             found_q;
  deq_pkg::pos_t    pos_q;

  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  logic [PTR_W-1:0]         mem_raddr;
  logic [deq_pkg::DATA_W-1:0] mem_rdata;

  logic [PTR_W-1:0] front_dec;
  logic             is_full;
  logic             rsp_load;
  logic [31:0]      count_ext;
  logic [31:0]      kc_ext;

  // Physical slot of logical position k counted from base.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(k);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign front_dec = (front_ptr == '0) ? PTR_W'(DEPTH - 1) : front_ptr - PTR_W'(1);
  assign is_full   = (count == CNT_W'(DEPTH));
  assign count_ext = 32'(count);
  assign kc_ext    = 32'(kc);
  assign req.ready = (state == S_IDLE);

  // The finished result moves into the output register once it is free.
  assign rsp_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // RAM port control. Only one request is in work, so a write and a read
  // never touch the same entry in overlapping cycles.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = front_dec;
    mem_raddr = slot_of(front_ptr, kc + CNT_W'(1));
    if (state == S_EXEC) begin
      case (req_type_q)
        deq_pkg::REQ_PUSH_FRONT: begin
          mem_we    = !is_full;
          mem_waddr = front_dec;
        end
        deq_pkg::REQ_PUSH_BACK: begin
          mem_we    = !is_full;
          mem_waddr = slot_of(front_ptr, count);
        end
        deq_pkg::REQ_REMOVE_FRONT: begin
          mem_raddr = slot_of(front_ptr, CNT_W'(2) - CNT_W'(1));
        end
        deq_pkg::REQ_REMOVE_BACK: begin
          mem_raddr = slot_of(front_ptr, count - CNT_W'(2));
        end
        deq_pkg::REQ_SEARCH: begin
          mem_raddr = slot_of(front_ptr, '0);
        end
        default: begin
        end
      endcase
    end
  end

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (value_q),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Request sequencer, queue state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_type_q <= req.req_type;
            value_q    <= req.value;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          found_q  <= 1'b0;
          pos_q    <= '0;
          kc       <= '0;
          case (req_type_q)
            deq_pkg::REQ_PUSH_FRONT: begin
              state <= S_DONE;
              if (is_full) begin
                status_q <= deq_pkg::ST_FULL;
              end else begin
                status_q  <= deq_pkg::ST_OK;
                front_ptr <= front_dec;
                count     <= count + CNT_W'(1);
                front_q   <= value_q;
                if (count == '0) begin
                  back_q <= value_q;
                end
              end
            end
            deq_pkg::REQ_PUSH_BACK: begin
              state <= S_DONE;
              if (is_full) begin
                status_q <= deq_pkg::ST_FULL;
              end else begin
                status_q <= deq_pkg::ST_OK;
                count    <= count + CNT_W'(1);
                back_q   <= value_q;
                if (count == '0) begin
                  front_q <= value_q;
                end
              end
            end
            deq_pkg::REQ_REMOVE_FRONT: begin
              if (count == '0) begin
                status_q <= deq_pkg::ST_EMPTY;
                state    <= S_DONE;
              end else begin
                status_q  <= deq_pkg::ST_OK;
                front_ptr <= slot_of(front_ptr, CNT_W'(1));
                count     <= count - CNT_W'(1);
                state     <= (count != CNT_W'(1)) ? S_LOAD : S_DONE;
              end
            end
            deq_pkg::REQ_REMOVE_BACK: begin
              if (count == '0) begin
                status_q <= deq_pkg::ST_EMPTY;
                state    <= S_DONE;
              end else begin
                status_q <= deq_pkg::ST_OK;
                count    <= count - CNT_W'(1);
                state    <= (count != CNT_W'(1)) ? S_LOAD : S_DONE;
              end
            end
            deq_pkg::REQ_SEARCH: begin
              status_q <= deq_pkg::ST_OK;
              state    <= (count != '0) ? S_SRCH : S_DONE;
            end
            default: begin
              status_q <= deq_pkg::ST_OK;
              state    <= S_DONE;
            end
          endcase
        end
        // The new end entry arrives from the RAM after a removal.
        S_LOAD: begin
          if (req_type_q == deq_pkg::REQ_REMOVE_FRONT) begin
            front_q <= mem_rdata;
          end else begin
            back_q <= mem_rdata;
          end
          state <= S_DONE;
        end
        // One entry per cycle; the next read is already issued.
        S_SRCH: begin
          if (mem_rdata == value_q) begin
            found_q <= 1'b1;
            pos_q   <= kc_ext[deq_pkg::POS_W-1:0];
            state   <= S_DONE;
          end else if (kc + CNT_W'(1) == count) begin
            state <= S_DONE;
          end else begin
            kc <= kc + CNT_W'(1);
          end
        end
        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (rsp_load) begin
            rsp.status      <= status_q;
            rsp.found       <= found_q;
            rsp.found_pos   <= pos_q;
            rsp.front_item  <= (count == '0) ? '0 : front_q;
            rsp.back_item   <= (count == '0) ? '0 : back_q;
            rsp.entry_count <= count_ext[deq_pkg::CNT_OUT_W-1:0];
            rsp.is_empty    <= (count == '0);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/deq_chk.sv
// Port-level checker for the deque block and the bind that attaches it.
// Depends on deq_pkg and the assertion macros header.
`include "double_ended_queue_with_search_defines.svh"

module deq_chk (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input deq_pkg::status_t status,
  input logic             found,
  input deq_pkg::pos_t    found_pos,
  input deq_pkg::data_t   front_item,
  input deq_pkg::data_t   back_item,
  input deq_pkg::cnt_t    entry_count,
  input logic             is_empty
);

  // No result is offered in the cycle after reset.
  `DEQ_ASSERT_ALWAYS(a_rst_no_rsp, rst |=> !rsp_valid, "result valid after reset")

  // An empty queue reports a zero count and zero end items.
  `DEQ_ASSERT(a_empty_view, rsp_valid && is_empty |-> entry_count == '0 && front_item == '0 && back_item == '0, "empty queue shows stale data")

  // A miss reports position zero, and the status is a defined code.
  `DEQ_ASSERT(a_miss_pos, rsp_valid && !found |-> found_pos == '0 && status != 2'd3, "bad position or status")

  // A full push can only be rejected while the queue holds entries.
  `DEQ_ASSERT(a_full_nonempty, rsp_valid && status == deq_pkg::ST_FULL |-> !is_empty && !found, "full status on empty queue")

  // A stalled result holds.
  `DEQ_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_item) && $stable(entry_count), "stalled result changed")

endmodule

bind double_ended_queue_with_search deq_chk u_deq_chk (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .found       (rsp.found),
  .found_pos   (rsp.found_pos),
  .front_item  (rsp.front_item),
  .back_item   (rsp.back_item),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty)
);

### test/deq_checker.sv
`timescale 1ns / 100ps
// Result checker for the deque block: watches both channels, predicts every result
// and compares it field by field. Depends on deq_pkg, deq_req_if and deq_rsp_if.
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  deq_req_if   req,
  deq_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding,
  output int   results_checked
);
  import deq_pkg::*;

  // One predicted result, laid out like the result channel payload.
  typedef struct packed {
    status_t status;
    logic    found;
    pos_t    found_pos;
    data_t   front_item;
    data_t   back_item;
    cnt_t    entry_count;
    logic    is_empty;
  } deq_view_t;

  // Shadow copy of the store: circular buffer, head slot and fill level.
  data_t       slot_mem [DEPTH];
  int unsigned head_slot  = 0;
  int unsigned fill_level = 0;

  // Predicted results waiting for their result transaction.
  deq_view_t expected_views [$];
  int        mismatches = 0;
  int        checked    = 0;

  function automatic int unsigned slot_at(int unsigned k);
    return (head_slot + k) % DEPTH;
  endfunction

  // Applies one request to the shadow store and returns the result it should cause.
  function automatic deq_view_t apply_request(req_t op, data_t v);
    deq_view_t   r;
    int unsigned k;
    r = '0;
    r.status = ST_OK;
    case (op)
      REQ_PUSH_FRONT: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slot_mem[head_slot] = v;
          fill_level++;
        end
      end
      REQ_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[slot_at(fill_level)] = v;
          fill_level++;
        end
      end
      REQ_REMOVE_FRONT: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head_slot = slot_at(1);
          fill_level--;
        end
      end
      REQ_REMOVE_BACK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          fill_level--;
        end
      end
      REQ_SEARCH: begin
        // Scan from the front and stop at the first match.
        k = 0;
        while (k < fill_level && !r.found) begin
          if (slot_mem[slot_at(k)] == v) begin
            r.found     = 1'b1;
            r.found_pos = pos_t'(k);
          end
          k++;
        end
      end
      default: ;
    endcase
    if (fill_level != 0) begin
      r.front_item = slot_mem[slot_at(0)];
      r.back_item  = slot_mem[slot_at(fill_level - 1)];
    end
    r.entry_count = cnt_t'(fill_level);
    r.is_empty    = (fill_level == 0);
    return r;
  endfunction

  // Reports one field that differs and returns 1 in that case.
  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Predict on every accepted request, compare on every accepted result.
  always @(posedge clk) begin : watch
    deq_view_t want;
    int        bad;
    if (rst) begin
      head_slot  = 0;
      fill_level = 0;
      expected_views.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_views.push_back(apply_request(req.req_type, req.value));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_views.size() == 0) begin
          $error("result transaction arrived with no request pending");
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          bad  = field_diff("status", 32'(want.status), 32'(rsp.status))
               + field_diff("found", 32'(want.found), 32'(rsp.found))
               + field_diff("found_pos", 32'(want.found_pos), 32'(rsp.found_pos))
               + field_diff("front_item", want.front_item, rsp.front_item)
               + field_diff("back_item", want.back_item, rsp.back_item)
               + field_diff("entry_count", 32'(want.entry_count), 32'(rsp.entry_count))
               + field_diff("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
          mismatches += bad;
          checked++;
        end
      end
    end
    outstanding     <= expected_views.size();
    fail_count      <= mismatches;
    results_checked <= checked;
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the deque block: drives requests, pulls results with random
// stalls and gives the verdict. Depends on deq_pkg, both channel interfaces and deq_checker.
module tb;
  import deq_pkg::*;

  localparam int    DEPTH        = DEPTH_DEF;
  localparam int    RANDOM_ITEMS = 1700;
  localparam int    IDLE_LIMIT   = 3000;
  localparam int    LONG_HOLD    = 300;
  localparam int    DRAIN_CYCLES = 50;
  localparam req_t  REQ_SPARE_FIRST = 3'd5;
  localparam req_t  REQ_SPARE_LAST  = 3'd7;
  localparam data_t DATA_MAX = 32'sh7FFFFFFF;
  localparam data_t DATA_MIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  int    fail_count;
  int    outstanding;
  int    results_checked;
  bit    no_idle      = 1'b0;
  int    hold_request = 0;
  int    request_total = 0;
  int    sent_by_op [8];
  data_t value_pool [8];

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_with_search #(.DEPTH(DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deq_checker #(.DEPTH(DEPTH)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Offers one request after a random gap and returns at the edge that accepts it.
  task automatic send_request(req_t op, data_t v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_by_op[op]++;
    if (op <= REQ_SEARCH) request_total++;
  endtask

  // Stops offering requests until every predicted result has been received.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // A small pool of values makes searches hit and duplicates common.
  task automatic refresh_pool();
    foreach (value_pool[i]) begin
      value_pool[i] = $urandom_range(0, 1) ? data_t'($urandom) : data_t'($urandom_range(0, 15));
    end
  endtask

  function automatic data_t pick_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 6) return value_pool[$urandom_range(0, 7)];
    if (pick == 7) return data_t'($urandom);
    if (pick == 8) return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
    return $urandom_range(0, 1) ? data_t'(0) : data_t'(-1);
  endfunction

  // Result side: random stalls per transaction, plus a long hold when requested.
  initial begin : result_sink
    int wait_cycles;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 19);
      if (hold_request > 0) begin
        wait_cycles += hold_request;
        hold_request = 0;
      end
      if (wait_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus: directed requests, then random segments, then the verdict.
  initial begin : stimulus
    int    code;
    int    i;
    int    n;
    int    kind;
    int    seg;
    data_t v;
    data_t back_tail;
    req_t  op;

    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_SEARCH;
    req_ch.value    <= '0;
    refresh_pool();
    back_tail = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Requests on the empty store, including the unused request codes.
    send_request(REQ_REMOVE_FRONT, DATA_MAX);
    send_request(REQ_REMOVE_BACK, DATA_MIN);
    send_request(REQ_SEARCH, '0);
    for (code = REQ_SPARE_FIRST; code <= REQ_SPARE_LAST; code++) begin
      send_request(req_t'(code), data_t'($urandom));
    end

    // Fill to capacity from both ends, starting with the value extremes.
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0, 4:    v = DATA_MAX;
        1:       v = DATA_MIN;
        2:       v = '0;
        3:       v = data_t'(-1);
        default: v = data_t'($urandom);
      endcase
      if (i % 2 == 0) begin
        back_tail = v;
        send_request(REQ_PUSH_BACK, v);
      end else begin
        send_request(REQ_PUSH_FRONT, v);
      end
    end

    // Pushes onto the full store, then searches: a duplicate, the last entry, a miss.
    send_request(REQ_PUSH_FRONT, DATA_MIN);
    send_request(REQ_PUSH_BACK, DATA_MAX);
    send_request(REQ_SEARCH, DATA_MAX);
    send_request(REQ_SEARCH, back_tail);
    send_request(REQ_SEARCH, 32'sh13579BDF);
    settle();

    // Random segments: fills, drains, mixed traffic, noise and bursts.
    seg = 0;
    while (request_total < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 9);
      no_idle = (kind == 9);
      if (seg == 3 || $urandom_range(0, 39) == 0) begin
        // Hold the result side off while a long run of pushes piles up.
        hold_request = LONG_HOLD;
        repeat (24) send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                 pick_value());
      end else begin
        case (kind)
          0, 1, 2: begin
            n = $urandom_range(4, 20);
            repeat (n) begin
              send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
              if ($urandom_range(0, 2) == 0) send_request(REQ_SEARCH, pick_value());
            end
          end
          3, 4: begin
            n = $urandom_range(4, 20);
            repeat (n) begin
              send_request($urandom_range(0, 1) ? REQ_REMOVE_FRONT : REQ_REMOVE_BACK,
                           data_t'($urandom));
              if ($urandom_range(0, 4) == 0) send_request(REQ_SEARCH, pick_value());
            end
          end
          8: begin
            n = $urandom_range(1, 6);
            repeat (n) begin
              op = req_t'($urandom_range(REQ_PUSH_FRONT, REQ_SPARE_LAST));
              send_request(op, data_t'($urandom));
            end
          end
          default: begin
            n = $urandom_range(5, 30);
            repeat (n) begin
              op = req_t'($urandom_range(REQ_PUSH_FRONT, REQ_SEARCH));
              send_request(op, pick_value());
            end
          end
        endcase
      end
      if ($urandom_range(0, 7) == 0) settle();
      if ($urandom_range(0, 5) == 0) refresh_pool();
      seg++;
    end

    // Let the last results drain, then watch for stray ones.
    no_idle = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pushes, %0d removals, %0d searches and %0d unused-code requests;",
             sent_by_op[REQ_PUSH_FRONT] + sent_by_op[REQ_PUSH_BACK],
             sent_by_op[REQ_REMOVE_FRONT] + sent_by_op[REQ_REMOVE_BACK],
             sent_by_op[REQ_SEARCH],
             sent_by_op[5] + sent_by_op[6] + sent_by_op[7]);
    $display("%0d results compared, %0d field mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_req_if.sv
rtl/deq_rsp_if.sv
rtl/deq_ram.sv
rtl/double_ended_queue_with_search.sv
rtl/deq_chk.sv
test/deq_checker.sv
test/tb.sv
